@@ design/sle_pkg.sv @@
// Shared types and constants of the sequential list engine.
package sle_pkg;

  // List capacity and the widths that follow from it
  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 8;
  localparam int LEN_W    = 8;
  localparam int DATA_W   = 32;
  // Compare width: holds the count, a position and count + 1
  localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_GET    = 2'd2,
    OP_LOCATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  value;
  } request_t;

  typedef struct packed {
    status_t                   status;
    logic signed [DATA_W-1:0]  read_value;
    logic [LEN_W-1:0]          found_position;
    logic [LEN_W-1:0]          list_length;
  } result_t;

  // Decoded command handed from the front end to the back end
  typedef struct packed {
    op_t                       op;
    logic                      pos_zero;
    logic [POS_W-1:0]          position;
    logic [ADDR_W-1:0]         index;
    logic signed [DATA_W-1:0]  value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MOVE,
    BK_PUT,
    BK_READ,
    BK_CAPTURE,
    BK_SCAN,
    BK_DONE
  } back_state_t;

endpackage

@@ design/sle_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/sle_front.sv @@
// Front end: accept requests, decode them and hold them in a two-entry command queue.
module sle_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             full,
  input  sle_pkg::request_t request,
  output logic             cmd_valid,
  output sle_pkg::cmd_t    cmd,
  input  logic             cmd_pop
);
  import sle_pkg::*;

  cmd_t             slot [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_push;
  logic             do_pop;
  cmd_t             decoded;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] pos_m1;

  assign full      = (fill == 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = slot[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = cmd_pop && cmd_valid;

  // Classify the request: flag position zero, form the 0-based index
  always_comb begin
    pos_ext          = {{(CMP_W-POS_W){1'b0}}, request.position};
    pos_m1           = pos_ext - {{(CMP_W-1){1'b0}}, 1'b1};
    decoded.op       = request.op;
    decoded.pos_zero = (request.position == '0);
    decoded.position = request.position;
    decoded.index    = pos_m1[ADDR_W-1:0];
    decoded.value    = request.value;
  end

  // Store the decoded command
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= decoded;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ design/sle_resq.sv @@
// Two-entry result queue between the back end and the result ports.
module sle_resq (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_push,
  output logic             res_full,
  input  sle_pkg::result_t res_in,
  output logic             empty,
  input  logic             pop,
  output sle_pkg::result_t result
);
  import sle_pkg::*;

  result_t    slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       do_push;
  logic       do_pop;

  assign res_full = (fill == 2'd2);
  assign empty    = (fill == 2'd0);
  assign result   = slot[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // Hold the pushed result
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= res_in;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({do_push, do_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

@@ design/sle_back.sv @@
// Back end: check each command against the list length and carry it out on the entry RAM.
module sle_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  sle_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_push,
  input  logic             res_full,
  output sle_pkg::result_t res
);
  import sle_pkg::*;

  back_state_t              state, state_next;
  logic [CNT_W-1:0]         count, count_next;
  logic [ADDR_W-1:0]        cur, cur_next;
  logic [ADDR_W-1:0]        last, last_next;
  logic                     shift_up, shift_up_next;
  logic                     rd_act, rd_act_next;
  logic                     pend, pend_next;
  logic [ADDR_W-1:0]        pend_addr, pend_addr_next;
  logic [ADDR_W-1:0]        index, index_next;
  logic signed [DATA_W-1:0] value, value_next;
  result_t                  res_next;

  logic                     we;
  logic [ADDR_W-1:0]        waddr;
  logic [DATA_W-1:0]        wdata;
  logic                     re;
  logic [ADDR_W-1:0]        raddr;
  logic [DATA_W-1:0]        rdata;

  logic [CMP_W-1:0]         pos_ext;
  logic [CMP_W-1:0]         cnt_ext;
  logic [CMP_W-1:0]         cnt_m1;
  logic [CMP_W-1:0]         len_ext;
  logic [CMP_W-1:0]         scan_pos;

  sle_ram #(
    .WIDTH(DATA_W),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign pos_ext  = {{(CMP_W-POS_W){1'b0}}, cmd.position};
  assign cnt_ext  = {{(CMP_W-CNT_W){1'b0}}, count};
  assign cnt_m1   = cnt_ext - {{(CMP_W-1){1'b0}}, 1'b1};
  assign len_ext  = {{(CMP_W-CNT_W){1'b0}}, count_next};
  assign scan_pos = {{(CMP_W-ADDR_W){1'b0}}, pend_addr} + {{(CMP_W-1){1'b0}}, 1'b1};

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= BK_IDLE;
      count  <= '0;
      rd_act <= 1'b0;
      pend   <= 1'b0;
    end else begin
      state  <= state_next;
      count  <= count_next;
      rd_act <= rd_act_next;
      pend   <= pend_next;
    end
  end

  // Walk and result payload
  always_ff @(posedge clk) begin
    cur       <= cur_next;
    last      <= last_next;
    shift_up  <= shift_up_next;
    pend_addr <= pend_addr_next;
    index     <= index_next;
    value     <= value_next;
    res       <= res_next;
  end

  // Sequence each command: check, walk the RAM one entry a cycle, report
  always_comb begin
    state_next     = state;
    count_next     = count;
    cur_next       = cur;
    last_next      = last;
    shift_up_next  = shift_up;
    rd_act_next    = rd_act;
    pend_next      = pend;
    pend_addr_next = pend_addr;
    index_next     = index;
    value_next     = value;
    res_next       = res;
    cmd_pop        = 1'b0;
    res_push       = 1'b0;
    we             = 1'b0;
    waddr          = pend_addr;
    wdata          = rdata;
    re             = 1'b0;
    raddr          = cur;

    unique case (state)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop                 = 1'b1;
          index_next              = cmd.index;
          value_next              = cmd.value;
          pend_next               = 1'b0;
          rd_act_next             = 1'b0;
          res_next.status         = ST_OK;
          res_next.read_value     = '0;
          res_next.found_position = '0;
          state_next              = BK_DONE;
          unique case (cmd.op)
            OP_INSERT: begin
              if (cmd.pos_zero || pos_ext > cnt_ext + {{(CMP_W-1){1'b0}}, 1'b1}) begin
                res_next.status = ST_BADPOS;
              end else if (cnt_ext == CAP_CMP) begin
                res_next.status = ST_FULL;
              end else begin
                count_next = count + {{(CNT_W-1){1'b0}}, 1'b1};
                if (pos_ext <= cnt_ext) begin
                  // move entries index..count-1 up by one, top first
                  cur_next      = cnt_m1[ADDR_W-1:0];
                  last_next     = cmd.index;
                  shift_up_next = 1'b1;
                  rd_act_next   = 1'b1;
                  state_next    = BK_MOVE;
                end else begin
                  state_next = BK_PUT;
                end
              end
            end
            OP_DELETE: begin
              if (cmd.pos_zero || pos_ext > cnt_ext) begin
                res_next.status = ST_BADPOS;
              end else begin
                count_next = count - {{(CNT_W-1){1'b0}}, 1'b1};
                if (pos_ext < cnt_ext) begin
                  // move entries position..count-1 down by one, bottom first
                  cur_next      = pos_ext[ADDR_W-1:0];
                  last_next     = cnt_m1[ADDR_W-1:0];
                  shift_up_next = 1'b0;
                  rd_act_next   = 1'b1;
                  state_next    = BK_MOVE;
                end
              end
            end
            OP_GET: begin
              if (cmd.pos_zero || pos_ext > cnt_ext) begin
                res_next.status = ST_BADPOS;
              end else begin
                state_next = BK_READ;
              end
            end
            OP_LOCATE: begin
              if (count != '0) begin
                cur_next    = '0;
                last_next   = cnt_m1[ADDR_W-1:0];
                rd_act_next = 1'b1;
                state_next  = BK_SCAN;
              end
            end
            default: begin
              res_next.status = ST_BADPOS;
            end
          endcase
        end
      end

      BK_MOVE: begin
        // write back the entry read in the previous cycle
        we = pend;
        if (rd_act) begin
          re             = 1'b1;
          pend_next      = 1'b1;
          pend_addr_next = shift_up ? cur + ADDR_W'(1) : cur - ADDR_W'(1);
          if (cur == last) begin
            rd_act_next = 1'b0;
          end else begin
            cur_next = shift_up ? cur - ADDR_W'(1) : cur + ADDR_W'(1);
          end
        end else begin
          pend_next  = 1'b0;
          state_next = shift_up ? BK_PUT : BK_DONE;
        end
      end

      BK_PUT: begin
        we         = 1'b1;
        waddr      = index;
        wdata      = value;
        state_next = BK_DONE;
      end

      BK_READ: begin
        re         = 1'b1;
        raddr      = index;
        state_next = BK_CAPTURE;
      end

      BK_CAPTURE: begin
        res_next.read_value = rdata;
        state_next          = BK_DONE;
      end

      BK_SCAN: begin
        if (rd_act) begin
          re             = 1'b1;
          pend_next      = 1'b1;
          pend_addr_next = cur;
          if (cur == last) begin
            rd_act_next = 1'b0;
          end else begin
            cur_next = cur + ADDR_W'(1);
          end
        end
        // compare the entry read in the previous cycle
        if (pend && ($signed(rdata) == value)) begin
          res_next.found_position = scan_pos[LEN_W-1:0];
          rd_act_next             = 1'b0;
          pend_next               = 1'b0;
          state_next              = BK_DONE;
        end else if (pend && !rd_act) begin
          pend_next  = 1'b0;
          state_next = BK_DONE;
        end
      end

      BK_DONE: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = BK_IDLE;
        end
      end

      default: begin
        state_next = BK_IDLE;
      end
    endcase

    // Length after the command
    if (state == BK_IDLE) begin
      res_next.list_length = len_ext[LEN_W-1:0];
    end
  end

endmodule

@@ design/sequential_list_engine.sv @@
// Top level of the sequential list engine.
// An ordered list of up to CAPACITY signed 32-bit entries held in one RAM, with
// insert, delete, get and locate requests taken through a queue-style port.
// Requests enter a two-entry command queue and results leave through a
// two-entry result queue, so up to two requests can be taken while the list
// works. The back end handles one request at a time and is bounded by the
// entry RAM, which moves or compares one entry per cycle. On an idle block the
// result can be taken in the cycle after the back end finishes; a full result
// queue holds the back end in its done state. A transfer on either side needs
// no wait state of its own.
module sequential_list_engine (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  sle_pkg::request_t request,
  output logic              empty,
  input  logic              pop,
  output sle_pkg::result_t  result
);
  import sle_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  logic    res_push;
  logic    res_full;
  result_t res;

  sle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  sle_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop),
    .res_push (res_push),
    .res_full (res_full),
    .res      (res)
  );

  sle_resq u_resq (
    .clk     (clk),
    .rst     (rst),
    .res_push(res_push),
    .res_full(res_full),
    .res_in  (res),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  // Back end takes a command only when one is queued
  a_cmd_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command taken from an empty command queue");

  // Back end pushes a result only when the result queue has room
  a_res_push_room: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full result queue");

  // A full-list result reports the list at capacity
  a_full_length: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status == ST_FULL) |-> (result.list_length == CAPACITY[LEN_W-1:0]))
    else $error("list-full result with a length other than capacity");

  // A rejected request reads nothing
  a_bad_no_data: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.status != ST_OK) |-> (result.read_value == '0))
    else $error("rejected request carries read data");

  // Both queues come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("queues not empty after reset");

endmodule
